[rtl/core/mrtu_pkg.sv]
`timescale 1ns / 1ps
package mrtu_pkg;

    localparam int unsigned MAX_READ_REGS   = 125;
    localparam int unsigned MAX_FRAME_BYTES = 256;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    localparam logic [7:0] FC_READ_HOLD = 8'h03;
    localparam logic [7:0] FC_WRITE_ONE = 8'h06;
    localparam logic [7:0] FC_WRITE_MUL = 8'h10;
    localparam logic [7:0] FC_EXC_WONE  = 8'h86;

    typedef enum logic [1:0] {
        REQ_START = 2'd0,
        REQ_VALUE = 2'd1,
        REQ_BYTE  = 2'd2,
        REQ_GAP   = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        FN_READ  = 2'd0,
        FN_WONE  = 2'd1,
        FN_WMUL  = 2'd2,
        FN_BAD   = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        OK_TX     = 2'd0,
        OK_REG    = 2'd1,
        OK_STATUS = 2'd2,
        OK_UNUSED = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_SEND = 2'd1,
        PH_RECV = 2'd2,
        PH_NONE = 2'd3
    } t_phase;

    typedef enum logic [3:0] {
        ST_OK        = 4'd0,
        ST_NO_DATA   = 4'd1,
        ST_INCOMPL   = 4'd2,
        ST_CRC       = 4'd3,
        ST_LENGTH    = 4'd4,
        ST_MISMATCH  = 4'd5,
        ST_BYTECOUNT = 4'd6,
        ST_EXCEPTION = 4'd7,
        ST_REGADDR   = 4'd8,
        ST_VALUE     = 4'd9,
        ST_BADCOUNT  = 4'd10,
        ST_EMPTY     = 4'd11
    } t_status;

    // byte-wide CRC-16 update, reflected polynomial
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

[rtl/core/modbus_rtu_master_frame_engine_top.sv]
`timescale 1ns / 1ps
// The item hold and step counter register each input transfer; the first step runs once
//   the output is free, and each step's result is registered at the end of that step.
// At most one result a cycle. A start or value word emits its bytes in turn, the CRC
//   after them when the frame is complete; a byte that closes the frame adds a status step.
// While a result waits unaccepted the sequencer halts and a held item stalls the input.
// Reset (i_rst_n low, synchronous): phase idle, CRCs to 0xFFFF, counters cleared.
module modbus_rtu_master_frame_engine_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_req_type,
    input  logic [7:0]  i_slave_addr,
    input  logic [1:0]  i_func_sel,
    input  logic [15:0] i_reg_addr,
    input  logic [15:0] i_count_or_value,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_last_value,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_out_kind,
    output logic [7:0]  o_tx_byte,
    output logic [15:0] o_reg_value,
    output logic [3:0]  o_status,
    output logic [7:0]  o_exception_code,
    output logic        o_last
);
    import mrtu_pkg::*;

    // held input item and step counter of the sequencer
    logic        r_busy;
    logic [2:0]  r_step;
    logic [1:0]  r_req_type;
    logic [7:0]  r_slave_addr;
    logic [1:0]  r_func_sel;
    logic [15:0] r_reg_addr;
    logic [15:0] r_cov;
    logic [7:0]  r_rx_byte;
    logic        r_last_value;

    // transaction state
    logic [7:0]  r_cur_slave,  n_cur_slave;
    logic [1:0]  r_cur_func,   n_cur_func;
    logic [15:0] r_cur_addr,   n_cur_addr;
    logic [15:0] r_cur_cv,     n_cur_cv;
    logic [6:0]  r_words,      n_words;
    logic [15:0] r_tx_crc,     n_tx_crc;
    logic [15:0] r_rx_crc,     n_rx_crc;
    logic [8:0]  r_rx_len,     n_rx_len;
    logic [7:0]  r_hold,       n_hold;
    t_phase      r_phase,      n_phase;
    logic [7:0]  r_hdr [6];

    // output register
    logic        r_ov;
    t_kind       r_kind;
    logic [7:0]  r_tx;
    logic [15:0] r_val;
    t_status     r_st;
    logic [7:0]  r_exc;
    logic        r_last;

    logic        out_free, adv, done, emit, hdr_we, in_xfer;
    logic [2:0]  hdr_idx;
    t_kind       e_kind;
    logic [7:0]  e_tx;
    logic [15:0] e_val;
    t_status     e_st;
    logic [7:0]  e_exc;

    // combinational helpers
    logic [17:0] two_n_item, two_n_cur, exp_len;
    logic [7:0]  fc_item, tx_b;
    t_status     start_err;
    logic        start_bad;
    logic [8:0]  len_d, new_len;
    logic [7:0]  word_idx;
    t_status     ev_st;
    logic [7:0]  ev_exc;
    logic        good;

    assign out_free = !r_ov || !i_stall;
    assign adv      = r_busy && out_free;
    assign o_stall  = r_busy && !(out_free && done);
    assign in_xfer  = i_valid && !o_stall;

    assign two_n_item = {1'b0, r_cov, 1'b0};
    assign two_n_cur  = {1'b0, r_cur_cv, 1'b0};
    assign exp_len    = (r_cur_func == FN_READ) ? 18'd5 + two_n_cur : 18'd8;
    assign good       = (r_rx_crc == 16'h0000);
    assign len_d      = r_rx_len - 9'd2;
    assign new_len    = r_rx_len + 9'd1;
    assign word_idx   = 8'((r_rx_len - 9'd4) >> 1);

    always_comb begin
        case (r_func_sel)
            FN_READ: fc_item = FC_READ_HOLD;
            FN_WONE: fc_item = FC_WRITE_ONE;
            default: fc_item = FC_WRITE_MUL;
        endcase
    end

    // request parameter check on start
    always_comb begin
        start_bad = 1'b1;
        start_err = ST_BADCOUNT;
        case (r_func_sel)
            FN_READ: begin
                start_bad = (r_cov == 16'd0) || (r_cov > 16'(MAX_READ_REGS))
                         || (18'd5 + two_n_item > 18'(MAX_FRAME_BYTES));
            end
            FN_WONE: start_bad = 1'b0;
            FN_WMUL: begin
                if (r_cov == 16'd0) begin
                    start_err = ST_EMPTY;
                end else begin
                    start_bad = (18'd9 + two_n_item > 18'(MAX_FRAME_BYTES));
                end
            end
            default: start_bad = 1'b1;
        endcase
    end

    // request byte chosen by step
    always_comb begin
        case (r_step)
            3'd0:    tx_b = r_slave_addr;
            3'd1:    tx_b = fc_item;
            3'd2:    tx_b = r_reg_addr[15:8];
            3'd3:    tx_b = r_reg_addr[7:0];
            3'd4:    tx_b = r_cov[15:8];
            3'd5:    tx_b = r_cov[7:0];
            default: tx_b = two_n_item[7:0];
        endcase
    end

    // response check, in priority order
    always_comb begin
        ev_st  = ST_OK;
        ev_exc = 8'h00;
        if (r_rx_len == 9'd0) begin
            ev_st = ST_NO_DATA;
        end else if (r_rx_len < 9'd4) begin
            ev_st = ST_INCOMPL;
        end else if (!good && ({9'd0, r_rx_len} < exp_len)) begin
            ev_st = ST_INCOMPL;
        end else if (!good) begin
            ev_st = ST_CRC;
        end else if (r_cur_func == FN_READ) begin
            if (len_d < 9'd3) begin
                ev_st = ST_LENGTH;
            end else if (r_hdr[0] != r_cur_slave || r_hdr[1] != FC_READ_HOLD) begin
                ev_st = ST_MISMATCH;
            end else if (r_hdr[2] != two_n_cur[7:0]) begin
                ev_st = ST_BYTECOUNT;
            end else if ({9'd0, len_d} != 18'd3 + two_n_cur) begin
                ev_st = ST_LENGTH;
            end
        end else if (r_cur_func == FN_WONE) begin
            if (len_d == 9'd3 && r_hdr[0] == r_cur_slave && r_hdr[1] == FC_EXC_WONE) begin
                ev_st  = ST_EXCEPTION;
                ev_exc = r_hdr[2];
            end else if (len_d < 9'd6) begin
                ev_st = ST_LENGTH;
            end else if (r_hdr[0] != r_cur_slave || r_hdr[1] != FC_WRITE_ONE) begin
                ev_st = ST_MISMATCH;
            end else if ({r_hdr[2], r_hdr[3]} != r_cur_addr) begin
                ev_st = ST_REGADDR;
            end else if ({r_hdr[4], r_hdr[5]} != r_cur_cv) begin
                ev_st = ST_VALUE;
            end
        end else begin
            if (len_d < 9'd6) begin
                ev_st = ST_LENGTH;
            end else if (r_hdr[0] != r_cur_slave || r_hdr[1] != FC_WRITE_MUL) begin
                ev_st = ST_MISMATCH;
            end
        end
    end

    // one sequencer step: at most one result and the state it leaves
    always_comb begin
        n_cur_slave = r_cur_slave;
        n_cur_func  = r_cur_func;
        n_cur_addr  = r_cur_addr;
        n_cur_cv    = r_cur_cv;
        n_words     = r_words;
        n_tx_crc    = r_tx_crc;
        n_rx_crc    = r_rx_crc;
        n_rx_len    = r_rx_len;
        n_hold      = r_hold;
        n_phase     = r_phase;
        hdr_we      = 1'b0;
        hdr_idx     = r_rx_len[2:0];
        done        = 1'b1;
        emit        = 1'b0;
        e_kind      = OK_TX;
        e_tx        = 8'h00;
        e_val       = 16'h0000;
        e_st        = ST_OK;
        e_exc       = 8'h00;
        case (t_req'(r_req_type))
            REQ_START: begin
                emit = 1'b1;
                if (r_step == 3'd0) begin
                    n_cur_slave = r_slave_addr;
                    n_cur_func  = r_func_sel;
                    n_cur_addr  = r_reg_addr;
                    n_cur_cv    = r_cov;
                    n_words     = 7'd0;
                    n_phase     = PH_IDLE;
                    n_tx_crc    = CRC_INIT;
                    if (start_bad) begin
                        e_kind = OK_STATUS;
                        e_st   = start_err;
                    end else begin
                        e_tx     = tx_b;
                        n_tx_crc = crc_byte(CRC_INIT, tx_b);
                        done     = 1'b0;
                    end
                end else if (r_step <= 3'd5 || (r_step == 3'd6 && r_func_sel == FN_WMUL)) begin
                    e_tx     = tx_b;
                    n_tx_crc = crc_byte(r_tx_crc, tx_b);
                    if (r_step == 3'd6) begin
                        n_phase = PH_SEND;
                    end else begin
                        done = 1'b0;
                    end
                end else if (r_step == 3'd6) begin
                    e_tx = r_tx_crc[7:0];
                    done = 1'b0;
                end else begin
                    e_tx     = r_tx_crc[15:8];
                    n_rx_crc = CRC_INIT;
                    n_rx_len = 9'd0;
                    n_phase  = PH_RECV;
                end
            end
            REQ_VALUE: begin
                if (r_step == 3'd0) begin
                    if (r_phase == PH_SEND) begin
                        emit = 1'b1;
                        if (r_last_value && ({9'd0, r_words} + 16'd1 < r_cur_cv)) begin
                            e_kind  = OK_STATUS;
                            e_st    = ST_BADCOUNT;
                            n_phase = PH_IDLE;
                        end else begin
                            e_tx     = r_cov[15:8];
                            n_tx_crc = crc_byte(r_tx_crc, r_cov[15:8]);
                            done     = 1'b0;
                        end
                    end
                end else if (r_step == 3'd1) begin
                    emit     = 1'b1;
                    e_tx     = r_cov[7:0];
                    n_tx_crc = crc_byte(r_tx_crc, r_cov[7:0]);
                    n_words  = r_words + 7'd1;
                    done     = ({9'd0, n_words} < r_cur_cv);
                end else if (r_step == 3'd2) begin
                    emit = 1'b1;
                    e_tx = r_tx_crc[7:0];
                    done = 1'b0;
                end else begin
                    emit     = 1'b1;
                    e_tx     = r_tx_crc[15:8];
                    n_rx_crc = CRC_INIT;
                    n_rx_len = 9'd0;
                    n_phase  = PH_RECV;
                end
            end
            REQ_BYTE: begin
                if (r_step == 3'd0) begin
                    if (r_phase == PH_RECV) begin
                        if (r_rx_len < 9'(MAX_FRAME_BYTES)) begin
                            n_rx_crc = crc_byte(r_rx_crc, r_rx_byte);
                            hdr_we   = (r_rx_len < 9'd6);
                            n_rx_len = new_len;
                            if (r_cur_func == FN_READ && r_rx_len >= 9'd3) begin
                                if (r_rx_len[0]) begin
                                    n_hold = r_rx_byte;
                                end else if (({8'd0, word_idx} < r_cur_cv)
                                          && r_hdr[0] == r_cur_slave
                                          && r_hdr[1] == FC_READ_HOLD
                                          && r_hdr[2] == two_n_cur[7:0]) begin
                                    emit   = 1'b1;
                                    e_kind = OK_REG;
                                    e_val  = {r_hold, r_rx_byte};
                                end
                            end
                        end
                        // frame end: evaluate in the next step on the updated CRC
                        done = !(({9'd0, n_rx_len} >= exp_len)
                              || (n_rx_len >= 9'(MAX_FRAME_BYTES)));
                    end
                end else begin
                    emit    = 1'b1;
                    e_kind  = OK_STATUS;
                    e_st    = ev_st;
                    e_exc   = ev_exc;
                    n_phase = PH_IDLE;
                end
            end
            default: begin
                if (r_phase == PH_RECV) begin
                    emit    = 1'b1;
                    e_kind  = OK_STATUS;
                    e_st    = ev_st;
                    e_exc   = ev_exc;
                    n_phase = PH_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_step      <= 3'd0;
            r_ov        <= 1'b0;
            r_cur_slave <= 8'h00;
            r_cur_func  <= 2'd0;
            r_cur_addr  <= 16'h0000;
            r_cur_cv    <= 16'h0000;
            r_words     <= 7'd0;
            r_tx_crc    <= CRC_INIT;
            r_rx_crc    <= CRC_INIT;
            r_rx_len    <= 9'd0;
            r_hold      <= 8'h00;
            r_phase     <= PH_IDLE;
        end else begin
            if (in_xfer) begin
                r_busy <= 1'b1;
                r_step <= 3'd0;
            end else if (adv && done) begin
                r_busy <= 1'b0;
            end else if (adv) begin
                r_step <= r_step + 3'd1;
            end
            if (out_free) begin
                r_ov <= adv && emit;
            end
            if (adv) begin
                r_cur_slave <= n_cur_slave;
                r_cur_func  <= n_cur_func;
                r_cur_addr  <= n_cur_addr;
                r_cur_cv    <= n_cur_cv;
                r_words     <= n_words;
                r_tx_crc    <= n_tx_crc;
                r_rx_crc    <= n_rx_crc;
                r_rx_len    <= n_rx_len;
                r_hold      <= n_hold;
                r_phase     <= n_phase;
            end
        end
    end

    // payload registers: item hold, header store, result
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_req_type   <= i_req_type;
            r_slave_addr <= i_slave_addr;
            r_func_sel   <= i_func_sel;
            r_reg_addr   <= i_reg_addr;
            r_cov        <= i_count_or_value;
            r_rx_byte    <= i_rx_byte;
            r_last_value <= i_last_value;
        end
        if (adv && hdr_we) begin
            r_hdr[hdr_idx] <= r_rx_byte;
        end
        if (adv && emit) begin
            r_kind <= e_kind;
            r_tx   <= e_tx;
            r_val  <= e_val;
            r_st   <= e_st;
            r_exc  <= e_exc;
            r_last <= (e_kind == OK_STATUS);
        end
    end

    assign o_valid          = r_ov;
    assign o_out_kind       = r_kind;
    assign o_tx_byte        = r_tx;
    assign o_reg_value      = r_val;
    assign o_status         = r_st;
    assign o_exception_code = r_exc;
    assign o_last           = r_last;

    // a final status always marks the end of the run
    a_last_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_last == (o_out_kind == OK_STATUS)))
        else $error("last flag disagrees with result kind");

    // no input stall while nothing is held
    a_idle_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> !o_stall)
        else $error("input stalled with empty item hold");

    // a final status leaves the engine idle
    a_status_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && emit && e_kind == OK_STATUS) |=> (r_phase == PH_IDLE))
        else $error("phase not idle after final status");

    // a register value only comes out while receiving
    a_reg_recv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && emit && e_kind == OK_REG) |-> (r_phase == PH_RECV))
        else $error("register value outside the receive phase");

endmodule
